// File: sv/atfc_pkg.sv
// ---------------------------------------------------------------------------
// Access token format checker package
// Shared character codes, expiry accumulator codes, limits and the
// end-of-token snapshot that passes from the scanner to the verdict stage.
// ---------------------------------------------------------------------------
package atfc_pkg;

  // Default longest token, in bytes
  localparam int DEF_MAX_LEN = 4096;

  // Characters the scanner looks for
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_S     = 8'h73;  // 's'
  localparam logic [7:0] CH_E     = 8'h65;  // 'e'
  localparam logic [7:0] CH_R     = 8'h72;  // 'r'
  localparam logic [7:0] CH_I     = 8'h69;  // 'i'
  localparam logic [7:0] CH_G     = 8'h67;  // 'g'
  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_9     = 8'h39;  // '9'

  // Decimal radix and the largest value that can take one more digit
  localparam logic [3:0]  RADIX_MAX_DIGIT_LOW = 4'd5;
  localparam logic [63:0] EXP_LIM_LOW  = 64'd1844674407370955161;  // digits 0 to 5
  localparam logic [63:0] EXP_LIM_HIGH = 64'd1844674407370955160;  // digits 6 to 9

  // Expiry accumulator state
  typedef enum logic [1:0] {
    CODE_RUN   = 2'd0,  // still taking digits
    CODE_DONE  = 2'd1,  // frozen with a good value
    CODE_BAD   = 2'd2,  // malformed or overflowed
    CODE_SPACE = 2'd3   // a space arrived while taking digits
  } exp_code_t;

  // End-of-token snapshot
  typedef struct packed {
    logic        format_ok;  // keys present, fields ordered, length kept
    exp_code_t   code;
    logic [63:0] value;
    logic [39:0] now;
  } snap_t;

endpackage

// File: sv/atfc_scan.sv
// ---------------------------------------------------------------------------
// Token scanner
// Per-byte key detection, field bound tracking and expiry accumulation.
// Produces the end-of-token snapshot on the final byte and clears itself.
// ---------------------------------------------------------------------------
module atfc_scan #(
  parameter int MAX_LEN = atfc_pkg::DEF_MAX_LEN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic [39:0]       now_i,
  output atfc_pkg::snap_t   snap_o
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_LEN);
  localparam logic [PW-1:0] POS_ONE = PW'(1);
  localparam logic [PW-1:0] POS_THREE = PW'(3);
  localparam logic [PW-1:0] POS_FOUR = PW'(4);

  // State
  logic [PW-1:0]         pos_r;
  logic [7:0]            rb_r [4];
  logic [63:0]           val_r [4];
  atfc_pkg::exp_code_t   code_r [4];
  logic                  ovf_r;
  logic                  se_start_v_r, se_stop_v_r;
  logic                  sr_start_v_r, sr_stop_v_r;
  logic                  sig_start_v_r, sig_stop_v_r;
  logic [PW-1:0]         se_start_r, se_stop_r;
  logic [PW-1:0]         sr_start_r, sr_stop_r;
  logic [PW-1:0]         sig_start_r, sig_stop_r;

  // Next field bounds
  logic                  se_start_v_nxt, se_stop_v_nxt;
  logic                  sr_start_v_nxt, sr_stop_v_nxt;
  logic                  sig_start_v_nxt, sig_stop_v_nxt;
  logic [PW-1:0]         se_start_nxt, se_stop_nxt;
  logic [PW-1:0]         sr_start_nxt, sr_stop_nxt;
  logic [PW-1:0]         sig_start_nxt, sig_stop_nxt;

  logic                  at_max;
  logic                  se_key, sr_key, sig_key;
  logic                  sep3_ok, sep4_ok;
  logic                  se_open, sr_open, sig_open;
  logic [PW-1:0]         pos_p1, pos_m3, pos_m4;
  logic                  void_key, fresh, freeze, freeze_late;

  logic [63:0]           base_val;
  atfc_pkg::exp_code_t   base_code;
  atfc_pkg::exp_code_t   frz_code;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [63:0]           mul_lim;
  logic                  mul_ovf;
  logic [63:0]           prod;
  logic [63:0]           val_nxt;
  atfc_pkg::exp_code_t   code_nxt;

  logic [PW-1:0]         len;
  logic                  se_fin_v, sr_fin_v, sig_fin_v;
  logic [PW-1:0]         se_fin, sr_fin, sig_fin;
  logic                  bounds_ok;
  logic                  clr;

  // Decode the current byte against recent history
  assign at_max   = (pos_r >= POS_MAX);
  assign se_key   = (byte_i == atfc_pkg::CH_EQ) && (rb_r[0] == atfc_pkg::CH_E) &&
                    (rb_r[1] == atfc_pkg::CH_S);
  assign sr_key   = (byte_i == atfc_pkg::CH_EQ) && (rb_r[0] == atfc_pkg::CH_R) &&
                    (rb_r[1] == atfc_pkg::CH_S);
  assign sig_key  = (byte_i == atfc_pkg::CH_EQ) && (rb_r[0] == atfc_pkg::CH_G) &&
                    (rb_r[1] == atfc_pkg::CH_I) && (rb_r[2] == atfc_pkg::CH_S);
  assign sep3_ok  = (rb_r[2] == atfc_pkg::CH_SPACE) || (rb_r[2] == atfc_pkg::CH_AMP);
  assign sep4_ok  = (rb_r[3] == atfc_pkg::CH_SPACE) || (rb_r[3] == atfc_pkg::CH_AMP);
  assign se_open  = se_start_v_r && !se_stop_v_r;
  assign sr_open  = sr_start_v_r && !sr_stop_v_r;
  assign sig_open = sig_start_v_r && !sig_stop_v_r;
  assign pos_p1   = pos_r + POS_ONE;
  assign pos_m3   = pos_r - POS_THREE;
  assign pos_m4   = pos_r - POS_FOUR;

  // Open new fields and close the one open field by priority
  always_comb begin
    se_start_v_nxt  = se_start_v_r;
    se_start_nxt    = se_start_r;
    se_stop_v_nxt   = se_stop_v_r;
    se_stop_nxt     = se_stop_r;
    sr_start_v_nxt  = sr_start_v_r;
    sr_start_nxt    = sr_start_r;
    sr_stop_v_nxt   = sr_stop_v_r;
    sr_stop_nxt     = sr_stop_r;
    sig_start_v_nxt = sig_start_v_r;
    sig_start_nxt   = sig_start_r;
    sig_stop_v_nxt  = sig_stop_v_r;
    sig_stop_nxt    = sig_stop_r;
    void_key        = 1'b0;
    fresh           = 1'b0;
    freeze          = 1'b0;
    freeze_late     = 1'b0;
    if (!at_max) begin
      if (se_key) begin
        if (sr_open) begin
          if (sep3_ok) begin
            sr_stop_v_nxt = 1'b1;
            sr_stop_nxt   = pos_m3;
          end else begin
            void_key = 1'b1;
          end
        end else if (sig_open) begin
          if (sep3_ok) begin
            sig_stop_v_nxt = 1'b1;
            sig_stop_nxt   = pos_m3;
          end else begin
            void_key = 1'b1;
          end
        end
        se_start_v_nxt = !void_key;
        se_start_nxt   = pos_p1;
        fresh          = 1'b1;
      end else if (sr_key) begin
        if (se_open) begin
          if (sep3_ok) begin
            se_stop_v_nxt = 1'b1;
            se_stop_nxt   = pos_m3;
            freeze        = 1'b1;
          end else begin
            void_key = 1'b1;
          end
        end else if (sig_open) begin
          if (sep3_ok) begin
            sig_stop_v_nxt = 1'b1;
            sig_stop_nxt   = pos_m3;
          end else begin
            void_key = 1'b1;
          end
        end
        sr_start_v_nxt = !void_key;
        sr_start_nxt   = pos_p1;
      end else if (sig_key) begin
        if (sr_open) begin
          if (sep4_ok) begin
            sr_stop_v_nxt = 1'b1;
            sr_stop_nxt   = pos_m4;
          end else begin
            void_key = 1'b1;
          end
        end else if (se_open) begin
          if (sep4_ok) begin
            se_stop_v_nxt = 1'b1;
            se_stop_nxt   = pos_m4;
            freeze        = 1'b1;
            freeze_late   = 1'b1;
          end else begin
            void_key = 1'b1;
          end
        end
        sig_start_v_nxt = !void_key;
        sig_start_nxt   = pos_p1;
      end
    end
  end

  // Pick the accumulator to continue from: newest, or the one before the key
  always_comb begin
    frz_code = freeze_late ? code_r[3] : code_r[2];
    if (freeze) begin
      base_val  = freeze_late ? val_r[3] : val_r[2];
      base_code = (frz_code == atfc_pkg::CODE_BAD) ? atfc_pkg::CODE_BAD :
                                                      atfc_pkg::CODE_DONE;
    end else begin
      base_val  = val_r[0];
      base_code = code_r[0];
    end
  end

  // Multiply by ten and add the digit; flag a carry out of 64 bits
  assign is_digit = (byte_i >= atfc_pkg::CH_0) && (byte_i <= atfc_pkg::CH_9);
  assign digit    = 4'(byte_i - atfc_pkg::CH_0);
  assign mul_lim  = (digit <= atfc_pkg::RADIX_MAX_DIGIT_LOW) ? atfc_pkg::EXP_LIM_LOW :
                                                              atfc_pkg::EXP_LIM_HIGH;
  assign mul_ovf  = (base_val > mul_lim);
  assign prod     = (base_val << 3) + (base_val << 1) + 64'(digit);

  // Advance the expiry accumulator
  always_comb begin
    val_nxt  = base_val;
    code_nxt = base_code;
    if (fresh) begin
      val_nxt  = '0;
      code_nxt = atfc_pkg::CODE_RUN;
    end else begin
      unique case (base_code)
        atfc_pkg::CODE_SPACE: code_nxt = atfc_pkg::CODE_BAD;
        atfc_pkg::CODE_RUN: begin
          if (byte_i == atfc_pkg::CH_AMP) begin
            code_nxt = atfc_pkg::CODE_DONE;
          end else if (is_digit) begin
            if (mul_ovf) begin
              val_nxt  = '1;
              code_nxt = atfc_pkg::CODE_BAD;
            end else begin
              val_nxt = prod;
            end
          end else if (byte_i == atfc_pkg::CH_SPACE) begin
            code_nxt = atfc_pkg::CODE_SPACE;
          end else begin
            code_nxt = atfc_pkg::CODE_BAD;
          end
        end
        atfc_pkg::CODE_DONE, atfc_pkg::CODE_BAD: ;
      endcase
    end
  end

  // End-of-token bounds: close the first open field at the token length
  assign len = at_max ? pos_r : pos_p1;

  always_comb begin
    se_fin_v  = se_stop_v_nxt;
    se_fin    = se_stop_nxt;
    sr_fin_v  = sr_stop_v_nxt;
    sr_fin    = sr_stop_nxt;
    sig_fin_v = sig_stop_v_nxt;
    sig_fin   = sig_stop_nxt;
    priority if (!se_stop_v_nxt) begin
      se_fin_v = 1'b1;
      se_fin   = len;
    end else if (!sr_stop_v_nxt) begin
      sr_fin_v = 1'b1;
      sr_fin   = len;
    end else if (!sig_stop_v_nxt) begin
      sig_fin_v = 1'b1;
      sig_fin   = len;
    end
  end

  assign bounds_ok = se_start_v_nxt && sr_start_v_nxt && sig_start_v_nxt &&
                     se_fin_v && (se_fin > se_start_nxt) &&
                     sr_fin_v && (sr_fin > sr_start_nxt) &&
                     sig_fin_v && (sig_fin > sig_start_nxt);

  // Snapshot for the verdict stage
  always_comb begin
    snap_o.format_ok = bounds_ok && !ovf_r && !at_max;
    snap_o.code      = at_max ? code_r[0] : code_nxt;
    snap_o.value     = at_max ? val_r[0] : val_nxt;
    snap_o.now       = now_i;
  end

  // Hold state; clear on reset and after every final byte
  assign clr = !rst_n || (step_i && last_i);

  always_ff @(posedge clk) begin
    if (clr) begin
      pos_r         <= '0;
      ovf_r         <= 1'b0;
      se_start_v_r  <= 1'b0;
      se_stop_v_r   <= 1'b0;
      sr_start_v_r  <= 1'b0;
      sr_stop_v_r   <= 1'b0;
      sig_start_v_r <= 1'b0;
      sig_stop_v_r  <= 1'b0;
      se_start_r    <= '0;
      se_stop_r     <= '0;
      sr_start_r    <= '0;
      sr_stop_r     <= '0;
      sig_start_r   <= '0;
      sig_stop_r    <= '0;
      for (int i = 0; i < 4; i++) begin
        rb_r[i]   <= '0;
        val_r[i]  <= '0;
        code_r[i] <= atfc_pkg::CODE_RUN;
      end
    end else if (step_i) begin
      if (at_max) begin
        ovf_r <= 1'b1;
      end else begin
        pos_r         <= pos_p1;
        se_start_v_r  <= se_start_v_nxt;
        se_start_r    <= se_start_nxt;
        se_stop_v_r   <= se_stop_v_nxt;
        se_stop_r     <= se_stop_nxt;
        sr_start_v_r  <= sr_start_v_nxt;
        sr_start_r    <= sr_start_nxt;
        sr_stop_v_r   <= sr_stop_v_nxt;
        sr_stop_r     <= sr_stop_nxt;
        sig_start_v_r <= sig_start_v_nxt;
        sig_start_r   <= sig_start_nxt;
        sig_stop_v_r  <= sig_stop_v_nxt;
        sig_stop_r    <= sig_stop_nxt;
        for (int i = 3; i > 0; i--) begin
          rb_r[i]   <= rb_r[i-1];
          val_r[i]  <= val_r[i-1];
          code_r[i] <= code_r[i-1];
        end
        rb_r[0]   <= byte_i;
        val_r[0]  <= val_nxt;
        code_r[0] <= code_nxt;
      end
    end
  end

  // Checks
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("byte position beyond the length limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && last_i |=> (pos_r == '0) && !ovf_r && !se_start_v_r)
    else $error("scanner not cleared after final byte");

  a_fresh_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && !last_i && !at_max && se_key |=>
      (code_r[0] == atfc_pkg::CODE_RUN) && (val_r[0] == '0))
    else $error("expiry accumulator not restarted by se key");

endmodule

// File: sv/atfc_judge.sv
// ---------------------------------------------------------------------------
// Verdict stage
// Holds the end-of-token snapshot, checks the expiry against the current
// time and registers the single-bit result for the output channel.
// ---------------------------------------------------------------------------
module atfc_judge (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              snap_load_i,
  input  atfc_pkg::snap_t   snap_i,
  output logic              snap_free_o,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_token_valid
);

  logic              snap_v_r;
  atfc_pkg::snap_t   snap_r;
  logic              out_valid_r;
  logic              out_token_valid_r;
  logic              out_free;
  logic              code_ok;
  logic              verdict;

  assign out_free    = !out_valid_r || out_ready;
  assign snap_free_o = !snap_v_r || out_free;

  // Judge the token: format ok, good code, nonzero expiry, not earlier than now
  assign code_ok = (snap_r.code == atfc_pkg::CODE_RUN) ||
                   (snap_r.code == atfc_pkg::CODE_DONE);
  assign verdict = snap_r.format_ok && code_ok && (snap_r.value != '0) &&
                   (snap_r.value >= {24'd0, snap_r.now});

  // Hold the snapshot until the result register takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else if (snap_load_i) begin
      snap_v_r <= 1'b1;
    end else if (out_free) begin
      snap_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load_i) begin
      snap_r <= snap_i;
    end
  end

  // Advance the result register whenever it is empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= snap_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_token_valid_r <= verdict;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_token_valid = out_token_valid_r;

  // Checks
  a_snap_moves: assert property (@(posedge clk) disable iff (!rst_n)
    snap_v_r && out_free |=> out_valid_r)
    else $error("held snapshot did not reach the result register");

endmodule

// File: sv/access_token_format_checker.sv
// ---------------------------------------------------------------------------
// Access token format checker
// Streams a signed-access token byte by byte and reports whether its
// se=, sr= and sig= fields are well formed and the expiry has not passed.
// ---------------------------------------------------------------------------
// One byte is taken every clock cycle unless a final byte stalls. Each
// byte passes through the input register, then the scanner updates the
// field bounds and the expiry accumulator; on the final byte of a token
// the scanner hands a snapshot to the verdict stage and clears itself, so
// the next token can follow at once. The verdict goes from the snapshot
// register to the output register, where out_valid shows it. Only a final
// byte can stall, and only while the previous verdict is still held in the
// output register and the snapshot register behind it. Bytes at positions
// from MAX_LEN on are dropped and make the verdict zero.
module access_token_format_checker #(
  parameter int MAX_LEN = atfc_pkg::DEF_MAX_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_token_byte,
  input  logic        in_last_byte,
  input  logic [39:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_token_valid
);

  logic              a_valid_r;
  logic [7:0]        a_byte_r;
  logic              a_last_r;
  logic [39:0]       a_now_r;
  logic              snap_free;
  logic              step;
  atfc_pkg::snap_t   snap;

  // Advance a held byte unless it is final and the verdict path is full
  assign step     = a_valid_r && (!a_last_r || snap_free);
  assign in_ready = !a_valid_r || step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid_r <= 1'b1;
    end else if (step) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte_r <= in_token_byte;
      a_last_r <= in_last_byte;
      a_now_r  <= in_now_seconds;
    end
  end

  atfc_scan #(
    .MAX_LEN (MAX_LEN)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .byte_i (a_byte_r),
    .last_i (a_last_r),
    .now_i  (a_now_r),
    .snap_o (snap)
  );

  atfc_judge u_judge (
    .clk             (clk),
    .rst_n           (rst_n),
    .snap_load_i     (step && a_last_r),
    .snap_i          (snap),
    .snap_free_o     (snap_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_valid (out_token_valid)
  );

  // Checks
  a_body_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !a_last_r |-> in_ready)
    else $error("non-final transaction stalled the input");

endmodule
